FILE: design/qog_pkg.sv
// Package for the quadratic objective gradient engine: widths, command codes,
// sequencer states, saturating add and magnitude helpers. No dependencies.
`default_nettype none

package qog_pkg;

  localparam int unsigned MaxColumns = 1024;
  localparam int unsigned IdxW       = $clog2(MaxColumns);
  localparam int unsigned LimW       = IdxW + 1;
  localparam int unsigned CfgW       = 11;
  localparam int unsigned ValW       = 32;
  localparam int unsigned AccW       = 48;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdLoad  = 2'd1,
    CmdEntry = 2'd2,
    CmdRead  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StRdSol,
    StTerm,
    StRdGj,
    StRdGi,
    StUpdI,
    StUpdJ,
    StOut
  } state_e;

  localparam logic signed [AccW-1:0] SatHi = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatLo = {1'b1, {(AccW-1){1'b0}}};

  // Saturating add of two 48-bit words.
  function automatic logic signed [AccW-1:0] sat_add(logic signed [AccW-1:0] a,
                                                     logic signed [AccW-1:0] b);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s > $signed({1'b0, SatHi})) sat_add = SatHi;
    else if (s < $signed({1'b1, SatLo})) sat_add = SatLo;
    else sat_add = s[AccW-1:0];
  endfunction

  // Magnitude of a 32-bit signed value.
  function automatic logic [ValW-1:0] mag32(logic signed [ValW-1:0] v);
    mag32 = v[ValW-1] ? ValW'(-v) : ValW'(v);
  endfunction

endpackage

`default_nettype wire

FILE: design/quadratic_objective_gradient.sv
// Top level of the quadratic objective gradient engine: sequencer, multiplier
// and accumulators. Depends on qog_pkg and qog_ram.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i/in_stall_o    | command, indices, values
//  out     | output    | out_valid_o/out_stall_i  | index, gradient, offset, flag
//  cfg     | input     | cfg_we_i                 | columns_in_use
//
// Start, load and rejected items leave the sequencer idle; a read goes to the output
// state, and a sparse entry steps through its states: the single RAM ports serialize
// the two solution reads and both gradient read-modify-writes, and one shared
// 32x32 multiplier forms the two halves in turn; the offset term has its own
// 32x32 and 16x32 products.
// Reset clears the offset and the flag and sets the limit to 1024; the RAMs need none.
// A result waits in the output register; the input stalls until it is taken.
`default_nettype none

module quadratic_objective_gradient
  import qog_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgW-1:0]        cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [1:0]             command_i,
  input  wire logic [IdxW-1:0]        index_i_i,
  input  wire logic [IdxW-1:0]        index_j_i,
  input  wire logic signed [ValW-1:0] linear_coeff_i,
  input  wire logic signed [ValW-1:0] solution_value_i,
  input  wire logic signed [ValW-1:0] quad_element_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [IdxW-1:0]             read_index_o,
  output logic signed [AccW-1:0]      gradient_value_o,
  output logic signed [AccW-1:0]      offset_value_o,
  output logic                        bad_index_seen_o
);

  state_e state_q, state_d;
  logic [CfgW-1:0] cols_q;
  logic signed [AccW-1:0] offset_q;
  logic bad_q;
  logic [IdxW-1:0] ii_q, jj_q;
  logic signed [ValW-1:0] q_q, xi_q, xj_q;
  logic signed [AccW-1:0] ti_q, tj_q;
  logic signed [AccW-1:0] gi_q;
  logic [1:0] phase_q;

  // Active limit is min(columns_in_use, MaxColumns).
  logic [LimW-1:0] lim;
  assign lim = (cols_q > CfgW'(MaxColumns)) ? LimW'(MaxColumns) : LimW'(cols_q);

  logic accept;
  assign in_stall_o = (state_q != StIdle);
  assign accept = in_valid_i && !in_stall_o;

  logic i_ok, j_ok;
  assign i_ok = ({1'b0, index_i_i} < lim);
  assign j_ok = ({1'b0, index_j_i} < lim);

  // Solution RAM port.
  logic sol_we;
  logic [IdxW-1:0] sol_addr;
  logic [ValW-1:0] sol_rdata;
  // Gradient RAM port.
  logic grd_we;
  logic [IdxW-1:0] grd_addr;
  logic [AccW-1:0] grd_wdata, grd_rdata;

  qog_ram #(.Width(ValW), .Depth(MaxColumns)) u_sol (
    .clk_i, .we_i(sol_we), .addr_i(sol_addr),
    .wdata_i(solution_value_i), .rdata_o(sol_rdata)
  );
  qog_ram #(.Width(AccW), .Depth(MaxColumns)) u_grd (
    .clk_i, .we_i(grd_we), .addr_i(grd_addr),
    .wdata_i(grd_wdata), .rdata_o(grd_rdata)
  );

  // Shared multiplier: magnitude product, registered.
  logic [ValW-1:0] ma, mb;
  logic [2*ValW-1:0] prod_q;
  logic neg_q;
  logic [2*ValW-1:0] prod_d;
  logic neg_d;
  assign prod_d = ma * mb;

  // Term from product: round(p / 2^17) with the sign applied.
  logic [2*ValW-1:0] rnd17;
  logic signed [AccW-1:0] term;
  assign rnd17 = (prod_q + 64'h10000) >> 17;
  assign term = neg_q ? -AccW'(rnd17) : AccW'(rnd17);

  // Offset term: tI (48 bits) times xi, split into high and low parts.
  logic [AccW-1:0] mg;
  logic [ValW-1:0] mx;
  assign mg = ti_q[AccW-1] ? AccW'(-ti_q) : AccW'(ti_q);
  assign mx = mag32(xi_q);
  logic [63:0] hi_prod_q, lo_prod_q;
  logic [64:0] off_m;
  logic [AccW:0] cl;
  logic signed [AccW+1:0] off_term, off_sum;
  logic signed [AccW-1:0] off_next;
  logic off_neg;
  assign off_neg = (ti_q[AccW-1] != xi_q[ValW-1]);
  assign off_m = {1'b0, hi_prod_q} + 65'((lo_prod_q + 64'h8000) >> 16);

  // The clamped term can reach 2^48, so the offset sum is formed wide and saturated.
  always_comb begin
    cl = (off_m > 65'(64'h1_0000_0000_0000)) ? {1'b1, {AccW{1'b0}}} : off_m[AccW:0];
    off_term = off_neg ? $signed({1'b0, cl}) : -$signed({1'b0, cl});
    off_sum = $signed({{2{offset_q[AccW-1]}}, offset_q}) + off_term;
    if (off_sum > $signed({2'b00, SatHi})) off_next = SatHi;
    else if (off_sum < $signed({2'b11, SatLo})) off_next = SatLo;
    else off_next = off_sum[AccW-1:0];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (cmd_e'(command_i))
            CmdStart: state_d = StIdle;
            CmdLoad:  state_d = StIdle;
            CmdEntry: state_d = (i_ok && j_ok) ? StRdSol : StIdle;
            CmdRead:  state_d = i_ok ? StRdGi : StOut;
            default:  state_d = StIdle;
          endcase
        end
      end
      StRdSol: state_d = (phase_q == 2'd1) ? StTerm : StRdSol;
      StTerm:  state_d = (phase_q == 2'd3) ? StRdGi : StTerm;
      StRdGi:  state_d = (phase_q == 2'd3) ? StOut : StUpdI;
      StUpdI:  state_d = StRdGj;
      StRdGj:  state_d = StUpdJ;
      StUpdJ:  state_d = StIdle;
      StOut:   state_d = out_stall_i ? StOut : StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Memory and multiplier controls.
  always_comb begin
    sol_we = 1'b0;
    sol_addr = ii_q;
    grd_we = 1'b0;
    grd_addr = ii_q;
    grd_wdata = grd_rdata;
    ma = mag32(q_q);
    mb = mag32(xj_q);
    neg_d = q_q[ValW-1] != xj_q[ValW-1];
    unique case (state_q)
      StIdle: begin
        sol_addr = index_i_i;
        grd_addr = index_i_i;
        grd_wdata = {{(AccW-ValW){linear_coeff_i[ValW-1]}}, linear_coeff_i};
        if (accept && cmd_e'(command_i) == CmdLoad && i_ok) begin
          sol_we = 1'b1;
          grd_we = 1'b1;
        end
      end
      StRdSol: begin
        sol_addr = jj_q;
        // x[j] arrives now and feeds the product for the i half directly.
        if (phase_q == 2'd1) begin
          mb = mag32(sol_rdata);
          neg_d = q_q[ValW-1] != sol_rdata[ValW-1];
        end
      end
      StTerm: begin
        if (phase_q == 2'd2) begin
          mb = mag32(xi_q);
          neg_d = q_q[ValW-1] != xi_q[ValW-1];
        end
      end
      StUpdI: begin
        grd_we = 1'b1;
        grd_wdata = sat_add(grd_rdata, ti_q);
      end
      StRdGj: grd_addr = jj_q;
      StUpdJ: begin
        grd_addr = jj_q;
        grd_we = 1'b1;
        grd_wdata = sat_add(grd_rdata, tj_q);
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q <= neg_d;
    hi_prod_q <= 64'(mg[AccW-1:16]) * 64'(mx);
    lo_prod_q <= 64'(mg[15:0]) * 64'(mx);
    if (accept) begin
      ii_q <= index_i_i;
      jj_q <= index_j_i;
      q_q <= quad_element_i;
    end
    if (state_q == StRdSol && phase_q == 2'd0) xi_q <= sol_rdata;
    if (state_q == StRdSol && phase_q == 2'd1) xj_q <= sol_rdata;
    if (state_q == StTerm && phase_q == 2'd2) ti_q <= term;
    if (state_q == StTerm && phase_q == 2'd3) tj_q <= term;
    if (state_q == StRdGi && phase_q == 2'd3) gi_q <= grd_rdata;
  end

  // Phase counter tags the sub-steps; phase 3 in StRdGi marks a read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
    end else if (accept) begin
      phase_q <= (cmd_e'(command_i) == CmdRead) ? 2'd3 : 2'd0;
    end else if (state_q == StRdSol || state_q == StTerm) begin
      phase_q <= phase_q + 2'd1;
    end
  end

  // Control state, offset and flag.
  logic off_en_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cols_q <= CfgW'(MaxColumns);
      offset_q <= '0;
      bad_q <= 1'b0;
      off_en_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cols_q <= cfg_wdata_i;
      off_en_q <= (state_q == StUpdI);
      if (off_en_q) offset_q <= off_next;
      if (accept) begin
        if (cmd_e'(command_i) == CmdStart) begin
          offset_q <= '0;
          bad_q <= 1'b0;
        end else if (!i_ok || (cmd_e'(command_i) == CmdEntry && !j_ok)) begin
          bad_q <= 1'b1;
        end
      end
      if (state_q == StOut && !out_stall_i) out_valid_o <= 1'b0;
      else if (state_q == StOut) out_valid_o <= 1'b1;
      else if (state_d == StOut) out_valid_o <= 1'b1;
    end
  end

  logic rd_ok_q;
  always_ff @(posedge clk_i) begin
    if (accept) rd_ok_q <= i_ok;
  end

  // Output fields.
  assign read_index_o = ii_q;
  assign gradient_value_o = rd_ok_q ? gi_q : '0;
  assign offset_value_o = offset_q;
  assign bad_index_seen_o = bad_q;

  // Checks on the sequencer.
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == StOut) else $error("result valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !accept) else $error("item accepted while busy");
  a_upd_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StUpdI |=> state_q == StRdGj) else $error("entry update out of order");

endmodule

`default_nettype wire

FILE: design/qog_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module qog_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One access per cycle; read data is registered and appears in the next cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

FILE: dv/qog_checker.sv
// Scoreboard for the quadratic objective gradient engine: watches the config
// port and both channels, predicts every read beat and compares it.
// Depends on qog_pkg.
`default_nettype none

module qog_checker
  import qog_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgW-1:0]        cfg_wdata_i,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_stall_i,
  input  wire logic [1:0]             command_i,
  input  wire logic [IdxW-1:0]        index_i_i,
  input  wire logic [IdxW-1:0]        index_j_i,
  input  wire logic signed [ValW-1:0] linear_coeff_i,
  input  wire logic signed [ValW-1:0] solution_value_i,
  input  wire logic signed [ValW-1:0] quad_element_i,
  input  wire logic                   out_valid_i,
  input  wire logic                   out_stall_i,
  input  wire logic [IdxW-1:0]        read_index_i,
  input  wire logic signed [AccW-1:0] gradient_value_i,
  input  wire logic signed [AccW-1:0] offset_value_i,
  input  wire logic                   bad_index_seen_i,
  output int                          errors_o,
  output int                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IdxW-1:0]        idx;
    logic signed [AccW-1:0] grad;
    logic signed [AccW-1:0] offs;
    logic                   bad;
  } grad_word_t;

  // Shadow copy of the engine state.
  longint          sol_mem  [MaxColumns];
  longint          grad_mem [MaxColumns];
  longint          offset_acc;
  logic            bad_seen;
  int unsigned     col_limit;
  grad_word_t      grad_words_q[$];

  localparam longint AccHi = 64'sd140737488355327;
  localparam longint AccLo = -64'sd140737488355328;

  function automatic longint clamp48(longint v);
    if (v > AccHi) return AccHi;
    if (v < AccLo) return AccLo;
    return v;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // Half of q*x in Q32.16, rounded half away from zero.
  function automatic longint half_product(longint a, longint b);
    longint unsigned m;
    m = (mag(a) * mag(b) + 64'h10000) >> 17;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Negated product of a gradient term with x, clamped to 2^48 in magnitude.
  function automatic longint offset_delta(longint g, longint x);
    longint unsigned mg, mx, m;
    mg = mag(g);
    mx = mag(x);
    m = (mg >> 16) * mx + (((mg & 64'hFFFF) * mx + 64'h8000) >> 16);
    if (m > (64'd1 << 48)) m = 64'd1 << 48;
    return ((g < 0) != (x < 0)) ? longint'(m) : -longint'(m);
  endfunction

  // Apply one accepted input beat to the shadow state.
  task automatic apply_beat();
    int unsigned lim, i, j;
    longint ti, tj, xi, xj;
    grad_word_t w;
    lim = (col_limit > MaxColumns) ? MaxColumns : col_limit;
    i = index_i_i;
    j = index_j_i;
    case (cmd_e'(command_i))
      CmdStart: begin
        offset_acc = 0;
        bad_seen = 1'b0;
      end
      CmdLoad: begin
        if (i >= lim) bad_seen = 1'b1;
        else begin
          grad_mem[i] = longint'(linear_coeff_i);
          sol_mem[i] = longint'(solution_value_i);
        end
      end
      CmdEntry: begin
        if (i >= lim || j >= lim) bad_seen = 1'b1;
        else begin
          xi = sol_mem[i];
          xj = sol_mem[j];
          ti = half_product(longint'(quad_element_i), xj);
          tj = half_product(longint'(quad_element_i), xi);
          grad_mem[i] = clamp48(grad_mem[i] + ti);
          grad_mem[j] = clamp48(grad_mem[j] + tj);
          offset_acc = clamp48(offset_acc + offset_delta(ti, xi));
        end
      end
      default: begin
        w.idx = index_i_i;
        w.grad = '0;
        if (i >= lim) bad_seen = 1'b1;
        else w.grad = grad_mem[i][AccW-1:0];
        w.offs = offset_acc[AccW-1:0];
        w.bad = bad_seen;
        grad_words_q.push_back(w);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grad_word_t got, want;
    if (!rst_ni) begin
      offset_acc = 0;
      bad_seen = 1'b0;
      col_limit = MaxColumns;
      grad_words_q.delete();
      errors_o = 0;
      pending_o = 0;
      foreach (sol_mem[k]) begin
        sol_mem[k] = 0;
        grad_mem[k] = 0;
      end
    end else begin
      if (cfg_we_i) col_limit = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) apply_beat();
      // Compare an output beat with the oldest predicted read.
      if (out_valid_i && !out_stall_i) begin
        got = '{read_index_i, gradient_value_i, offset_value_i, bad_index_seen_i};
        if (grad_words_q.size() == 0) begin
          $display("%0t: output beat with no read pending: idx=%0d grad=%0d", $time,
                   got.idx, got.grad);
          errors_o++;
        end else begin
          want = grad_words_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected idx=%0d grad=%0d off=%0d bad=%0b", $time,
                     want.idx, want.grad, want.offs, want.bad);
            $display("%0t:          actual   idx=%0d grad=%0d off=%0d bad=%0b", $time,
                     got.idx, got.grad, got.offs, got.bad);
            errors_o++;
          end
        end
      end
      pending_o = grad_words_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Top of the gradient engine testbench: clock, reset, stimulus and verdict.
// Depends on qog_pkg, quadratic_objective_gradient and qog_checker.
`default_nettype none

module testbench;
  import qog_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgW-1:0]        cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             command_i = CmdStart;
  logic [IdxW-1:0]        index_i_i = '0;
  logic [IdxW-1:0]        index_j_i = '0;
  logic signed [ValW-1:0] linear_coeff_i = '0;
  logic signed [ValW-1:0] solution_value_i = '0;
  logic signed [ValW-1:0] quad_element_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b1;
  logic [IdxW-1:0]        read_index_o;
  logic signed [AccW-1:0] gradient_value_o;
  logic signed [AccW-1:0] offset_value_o;
  logic                   bad_index_seen_o;
  int                     errors;
  int                     pending;

  int          cur_limit = MaxColumns;
  int          loaded_q[$];
  bit          loaded[MaxColumns];
  bit          no_gaps;
  int          hold_reqs = 0;

  always #10 clk_i = ~clk_i;

  quadratic_objective_gradient u_dut (.*);

  qog_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_stall_i(in_stall_o), .command_i, .index_i_i, .index_j_i, .linear_coeff_i,
    .solution_value_i, .quad_element_i, .out_valid_i(out_valid_o), .out_stall_i,
    .read_index_i(read_index_o), .gradient_value_i(gradient_value_o),
    .offset_value_i(offset_value_o), .bad_index_seen_i(bad_index_seen_o),
    .errors_o(errors), .pending_o(pending)
  );

  // Mostly short idle stretches, a few long ones.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Receiver: random stall, or a long hold-off when one is requested.
  initial begin
    int hold_left, hold_seen, run;
    hold_left = 0;
    hold_seen = 0;
    run = 0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else if (run > 0) begin
        run--;
      end else begin
        run = idle_len();
        out_stall_i = (run > 0);
      end
    end
  end

  function automatic int eff_limit();
    return cur_limit > MaxColumns ? MaxColumns : cur_limit;
  endfunction

  function automatic logic signed [ValW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
  endfunction

  // Pick a loaded index inside the current limit, or -1 if there is none.
  function automatic int pick_loaded();
    int c[$];
    int lim;
    lim = eff_limit();
    c = loaded_q.find(x) with (x < lim);
    return c.size() ? c[$urandom_range(0, c.size() - 1)] : -1;
  endfunction

  // Offer one beat and wait until it is taken.
  task automatic send(cmd_e cmd, int i, int j, logic [ValW-1:0] a, logic [ValW-1:0] b,
                      logic [ValW-1:0] q);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i = cmd;
    index_i_i = IdxW'(i);
    index_j_i = IdxW'(j);
    linear_coeff_i = a;
    solution_value_i = b;
    quad_element_i = q;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (cmd == CmdLoad && i < eff_limit() && !loaded[i]) begin
      loaded[i] = 1'b1;
      loaded_q.push_back(i);
    end
  endtask

  // Drain the engine, let a sparse entry finish, then write the limit.
  task automatic set_limit(int value);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = CfgW'(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cur_limit = value;
  endtask

  // An index at or above the limit, when the limit leaves room for one.
  function automatic int bad_index();
    return eff_limit() < MaxColumns ? $urandom_range(eff_limit(), MaxColumns - 1) : 0;
  endfunction

  // One random beat, mostly well formed with occasional bad indices.
  task automatic random_beat();
    int r, i, j;
    r = $urandom_range(0, 99);
    i = pick_loaded();
    j = pick_loaded();
    if ($urandom_range(0, 19) == 0 && eff_limit() < MaxColumns) begin
      if ($urandom_range(0, 1)) i = bad_index();
      else j = bad_index();
      if (i < 0) i = 0;
      if (j < 0) j = 0;
    end
    if (r < 4) begin
      send(CmdStart, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom, $urandom,
           $urandom);
    end else if (r < 28 || i < 0 || j < 0) begin
      i = (eff_limit() > 0) ? $urandom_range(0, eff_limit() - 1) : $urandom_range(0, 1023);
      if ($urandom_range(0, 3) == 0 && loaded_q.size() > 0 && eff_limit() == MaxColumns)
        i = $urandom_range(0, 1023);
      send(CmdLoad, i, $urandom_range(0, 1023), rand_value(), rand_value(), $urandom);
    end else if (r < 74) begin
      send(CmdEntry, i, ($urandom_range(0, 9) == 0) ? i : j, $urandom, $urandom,
           rand_value());
    end else begin
      send(CmdRead, i, $urandom_range(0, 1023), $urandom, $urandom, $urandom);
    end
  endtask

  // Stimulus.
  initial begin
    int limits[6];
    limits = '{MaxColumns, 2047, 600, 1, 0, 0};
    limits[5] = $urandom_range(2, 1024);
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    set_limit(MaxColumns);

    // Directed: extremes, the diagonal case, saturation and bad indices.
    send(CmdStart, 0, 0, 0, 0, 0);
    send(CmdLoad, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 0);
    send(CmdLoad, 1023, 0, 32'sh80000000, 32'sh80000000, 0);
    send(CmdLoad, 1, 0, 32'sh00010000, 32'shffff8000, 0);
    send(CmdLoad, 2, 0, 0, 32'sh00018000, 0);
    send(CmdEntry, 0, 0, 0, 0, 32'sh7fffffff);
    repeat (4) send(CmdEntry, 0, 1023, 0, 0, 32'sh80000000);
    send(CmdEntry, 1023, 1023, 0, 0, 32'sh7fffffff);
    send(CmdRead, 0, 0, 0, 0, 0);
    send(CmdRead, 1023, 0, 0, 0, 0);
    send(CmdEntry, 1, 2, 0, 0, 32'sh00030000);
    send(CmdRead, 2, 0, 0, 0, 0);
    send(CmdStart, 0, 0, 0, 0, 0);
    send(CmdRead, 1, 0, 0, 0, 0);
    set_limit(1);
    send(CmdLoad, 5, 0, 1, 1, 0);
    send(CmdEntry, 0, 3, 0, 0, 1);
    send(CmdRead, 700, 0, 0, 0, 0);
    send(CmdStart, 0, 0, 0, 0, 0);
    send(CmdRead, 0, 0, 0, 0, 0);
    set_limit(0);
    send(CmdLoad, 0, 0, 1, 1, 0);
    send(CmdRead, 0, 0, 0, 0, 0);

    // Random phases over several limits, one with a long receiver hold-off.
    foreach (limits[p]) begin
      set_limit(limits[p]);
      no_gaps = (p == 2);
      for (int n = 0; n < ((limits[p] < 2) ? 60 : 325); n++) begin
        if (p == 1 && n == 40) hold_reqs++;
        random_beat();
      end
    end
    set_limit(MaxColumns);
    in_valid_i = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
